### hdl/hcbd_pkg.sv
package hcbd_pkg;

   // Field widths of the decoder state.
   localparam int SIZE_W  = 28;
   localparam int LINE_W  = 4;
   localparam int COUNT_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Default limit on size-line length.
   localparam int DEFAULT_MAX_SIZE_CHARS = 8;

   // Queue between the classifier and the decoder.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_ENDED,
      PH_ERROR,
      PH_EMPTY
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUNNING,
      ST_ENDED,
      ST_TOO_LONG,
      ST_EMPTY
   } status_type;

   // One classified body byte.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_cr;
      logic       is_lf;
      logic       is_hex;
      logic [3:0] hex_val;
   } item_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Size-line parser state.
   typedef struct packed {
      phase_type         phase;
      logic [SIZE_W-1:0] acc;
      logic [LINE_W-1:0] chars;
      logic              hex_open;
   } line_type;

endpackage

### hdl/hcbd_front.sv
module hcbd_front
   import hcbd_pkg::*;
(
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output item_type   item
);

   // Classify the byte: line terminators and hex digit value.
   always_comb begin
      item.data    = data_byte;
      item.last    = last_byte;
      item.is_cr   = (data_byte == CH_CR);
      item.is_lf   = (data_byte == CH_LF);
      item.is_hex  = 1'b0;
      item.hex_val = data_byte[3:0];
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         item.is_hex = 1'b1;
      end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                   (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
         item.is_hex  = 1'b1;
         item.hex_val = 4'(data_byte[3:0] + 4'd9);
      end
   end

endmodule

### hdl/hcbd_queue.sv
module hcbd_queue
   import hcbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   push_item,
   input  logic       pop,
   output item_type   head_item,
   output q_stat_type stat
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/hcbd_back.sv
module hcbd_back
   import hcbd_pkg::*;
#(
   parameter int MAX_SIZE_CHARS = DEFAULT_MAX_SIZE_CHARS
)
(
   input  logic               clock,
   input  logic               reset,
   input  item_type           item,
   input  q_stat_type         q_stat,
   output logic               pop,
   input  logic               out_ready,
   output logic               out_valid,
   output logic               payload_valid,
   output logic [7:0]         payload_byte,
   output logic [1:0]         body_status,
   output logic [COUNT_W-1:0] payload_count
);

   line_type           line_ff, line_in;
   logic [SIZE_W-1:0]  remain_ff, remain_in;
   logic               first_ff, first_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               out_valid_ff;
   logic               pay_valid_ff, pay_valid_in;
   logic [7:0]         pay_byte_ff;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] out_count_ff;

   function automatic line_type begin_line();
      line_type r;
      r.phase    = PH_SIZE;
      r.acc      = '0;
      r.chars    = '0;
      r.hex_open = 1'b1;
      return r;
   endfunction

   // Count one size-line character and fold in a hex digit while digits are open.
   function automatic line_type count_char(line_type s, logic is_hex, logic [3:0] v);
      line_type          r;
      logic [LINE_W-1:0] n;
      r       = s;
      n       = LINE_W'(s.chars + 1'b1);
      r.chars = n;
      if (n >= LINE_W'(MAX_SIZE_CHARS)) begin
         r.phase = PH_ERROR;
      end else if (s.hex_open && is_hex) begin
         if (s.acc[SIZE_W-1 -: 4] != '0) begin
            r.acc = '1;
         end else begin
            r.acc = {s.acc[SIZE_W-5:0], v};
         end
      end else begin
         r.hex_open = 1'b0;
      end
      return r;
   endfunction

   function automatic line_type size_byte(line_type s, item_type it);
      line_type r;
      r = s;
      if (it.is_cr) begin
         r.phase = PH_SIZE_LF;
      end else begin
         r = count_char(s, it.is_hex, it.hex_val);
      end
      return r;
   endfunction

   // Take the head item whenever the output register is free or being drained.
   assign pop = !q_stat.empty && (!out_valid_ff || out_ready);

   // Decoder step for the head item.
   always_comb begin
      line_in      = line_ff;
      remain_in    = remain_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      pay_valid_in = 1'b0;
      case (line_ff.phase)
         PH_SIZE: begin
            line_in = size_byte(line_ff, item);
         end
         PH_SIZE_LF: begin
            if (item.is_lf) begin
               if (line_ff.acc == '0) begin
                  line_in.phase = first_ff ? PH_EMPTY : PH_ENDED;
               end else begin
                  remain_in     = line_ff.acc;
                  first_in      = 1'b0;
                  line_in.phase = PH_DATA;
               end
            end else begin
               // A bare CR counts as an ordinary character.
               line_in.phase = PH_SIZE;
               line_in       = count_char(line_in, 1'b0, 4'd0);
               if (line_in.phase != PH_ERROR) begin
                  line_in = size_byte(line_in, item);
               end
            end
         end
         PH_DATA: begin
            pay_valid_in = 1'b1;
            if (count_ff != COUNT_MAX) begin
               count_in = COUNT_W'(count_ff + 1'b1);
            end
            remain_in = SIZE_W'(remain_ff - 1'b1);
            if (remain_in == '0) begin
               line_in.phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            if (item.is_cr) begin
               line_in.phase = PH_DATA_LF;
            end else begin
               line_in = size_byte(begin_line(), item);
            end
         end
         PH_DATA_LF: begin
            line_in = begin_line();
            if (!item.is_lf) begin
               line_in = size_byte(line_in, item);
            end
         end
         default: begin
         end
      endcase

      case (line_in.phase)
         PH_ENDED: status_in = ST_ENDED;
         PH_ERROR: status_in = ST_TOO_LONG;
         PH_EMPTY: status_in = ST_EMPTY;
         default:  status_in = item.last ? ST_ENDED : ST_RUNNING;
      endcase
   end

   // Decoder state; a last-marked byte restarts the body.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= begin_line();
         remain_ff <= '0;
         first_ff  <= 1'b1;
         count_ff  <= '0;
      end else if (pop) begin
         if (item.last) begin
            line_ff   <= begin_line();
            remain_ff <= '0;
            first_ff  <= 1'b1;
            count_ff  <= '0;
         end else begin
            line_ff   <= line_in;
            remain_ff <= remain_in;
            first_ff  <= first_in;
            count_ff  <= count_in;
         end
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         pay_valid_ff <= pay_valid_in;
         pay_byte_ff  <= pay_valid_in ? item.data : 8'd0;
         status_ff    <= status_in;
         out_count_ff <= count_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign payload_valid = pay_valid_ff;
   assign payload_byte  = pay_byte_ff;
   assign body_status   = status_ff;
   assign payload_count = out_count_ff;

endmodule

### hdl/http_chunked_body_decoder_top.sv
// Each input transfer is written into the queue storage and then into the
// output register before its result appears on rsp_tvalid.
// Throughput: one byte per cycle while rsp_tready stays high; a four-entry
// queue between the classifier and the decoder absorbs output stalls before req_tready drops.
// Reset (synchronous, active high) empties the queue, drops rsp_tvalid and
// returns the decoder to the size line of the first chunk.
module http_chunked_body_decoder_top
   import hcbd_pkg::*;
#(
   parameter int MAX_SIZE_CHARS = DEFAULT_MAX_SIZE_CHARS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // payload_byte[7:0], body_status[9:8],
                                    // payload_count[26:10], zero fill
   output logic        rsp_tuser    // payload_valid
);

   item_type           front_item;
   item_type           head_item;
   q_stat_type         q_stat;
   logic               push;
   logic               pop;
   logic [7:0]         payload_byte;
   logic [1:0]         body_status;
   logic [COUNT_W-1:0] payload_count;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   hcbd_front u_front (
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .item      (front_item)
   );

   hcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   hcbd_back #(
      .MAX_SIZE_CHARS (MAX_SIZE_CHARS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item          (head_item),
      .q_stat        (q_stat),
      .pop           (pop),
      .out_ready     (rsp_tready),
      .out_valid     (rsp_tvalid),
      .payload_valid (rsp_tuser),
      .payload_byte  (payload_byte),
      .body_status   (body_status),
      .payload_count (payload_count)
   );

   assign rsp_tdata = {5'd0, payload_count, body_status, payload_byte};

   // A data byte is only ever passed while the body is still running or ends on it.
   a_payload_status : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[9] == 1'b0)
      else $error("payload byte reported with a terminal error status");

   // Non-payload results carry a zero byte.
   a_zero_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("non-payload result carries a nonzero byte");

   // The decoder never pops an empty queue.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue popped while empty");

endmodule

### test/http_chunked_body_decoder_top_tb.sv
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_tb;
   import hcbd_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int MAX_CHARS      = DEFAULT_MAX_SIZE_CHARS;
   localparam int PIPE_LATENCY   = 2;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int CALM_TAIL      = 150;
   localparam int HOLD_AFTER     = 600;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [SIZE_W-1:0] SIZE_ALL = '1;

   // One decoded result as the block reports it.
   typedef struct packed {
      logic               valid;
      logic [7:0]         pbyte;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } decoded_type;

   // One body byte to send, with an optional typed-in expectation.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        fixed;
      decoded_type want;
   } body_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // payload_byte[7:0], body_status[9:8],
                             // payload_count[26:10], zero fill
   logic        rsp_tuser;   // payload_valid

   body_byte_type body_q[$];
   decoded_type   decoded_q[$];

   int total_items;
   int results_seen;
   int mismatch_count;
   int idle_cycles;
   bit rsp_hold;
   bit hold_done;

   // Shadow copy of the decoder state.
   phase_type          dec_phase;
   logic [SIZE_W-1:0]  chunk_left;
   logic [SIZE_W-1:0]  size_acc;
   logic [LINE_W-1:0]  line_len;
   logic               hex_open;
   logic               first_chunk;
   logic [COUNT_W-1:0] emitted;

   http_chunked_body_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------

   function automatic void start_line();
      dec_phase = PH_SIZE;
      size_acc  = '0;
      line_len  = '0;
      hex_open  = 1'b1;
   endfunction

   function automatic void restart_decoder();
      start_line();
      chunk_left  = '0;
      first_chunk = 1'b1;
      emitted     = '0;
   endfunction

   // Count one size-line character and fold it into the size while the
   // leading hex digits last.
   function automatic void count_char(input logic [7:0] b);
      logic       is_hex;
      logic [3:0] nib;
      line_len = line_len + 1'b1;
      if (line_len >= MAX_CHARS) begin
         dec_phase = PH_ERROR;
         return;
      end
      is_hex = 1'b1;
      if (b >= "0" && b <= "9") nib = 4'(b - "0");
      else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
      else begin
         is_hex = 1'b0;
         nib    = '0;
      end
      if (hex_open && is_hex) begin
         if (size_acc > (SIZE_ALL >> 4)) size_acc = SIZE_ALL;
         else size_acc = {size_acc[SIZE_W-5:0], nib};
      end else begin
         hex_open = 1'b0;
      end
   endfunction

   function automatic void size_char(input logic [7:0] b);
      if (b == CH_CR) dec_phase = PH_SIZE_LF;
      else count_char(b);
   endfunction

   // Advance the model by one body byte and return the result it causes.
   function automatic decoded_type decode_byte(input logic [7:0] b, input logic last);
      decoded_type r;
      r = '0;
      case (dec_phase)
         PH_SIZE: size_char(b);
         PH_SIZE_LF: begin
            if (b == CH_LF) begin
               if (size_acc == '0) begin
                  dec_phase = first_chunk ? PH_EMPTY : PH_ENDED;
               end else begin
                  chunk_left  = size_acc;
                  first_chunk = 1'b0;
                  dec_phase   = PH_DATA;
               end
            end else begin
               // A CR without its LF is an ordinary size-line character.
               dec_phase = PH_SIZE;
               count_char(CH_CR);
               if (dec_phase != PH_ERROR) size_char(b);
            end
         end
         PH_DATA: begin
            r.valid = 1'b1;
            if (emitted != COUNT_MAX) emitted = emitted + 1'b1;
            chunk_left = chunk_left - 1'b1;
            if (chunk_left == '0) dec_phase = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (b == CH_CR) begin
               dec_phase = PH_DATA_LF;
            end else begin
               start_line();
               size_char(b);
            end
         end
         PH_DATA_LF: begin
            start_line();
            if (b != CH_LF) size_char(b);
         end
         default: ;
      endcase
      case (dec_phase)
         PH_ENDED: r.status = ST_ENDED;
         PH_ERROR: r.status = ST_TOO_LONG;
         PH_EMPTY: r.status = ST_EMPTY;
         default:  r.status = last ? ST_ENDED : ST_RUNNING;
      endcase
      r.pbyte = r.valid ? b : 8'h00;
      r.count = emitted;
      if (last) restart_decoder();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------

   function automatic void add_byte(input logic [7:0] d, input logic l);
      body_byte_type row;
      row       = '0;
      row.data  = d;
      row.last  = l;
      body_q.push_back(row);
   endfunction

   function automatic void add_fixed(input logic [7:0] d, input logic l, input logic v,
                                     input logic [7:0] pb, input status_type st,
                                     input logic [COUNT_W-1:0] cnt);
      body_byte_type row;
      row             = '0;
      row.data        = d;
      row.last        = l;
      row.fixed       = 1'b1;
      row.want.valid  = v;
      row.want.pbyte  = pb;
      row.want.status = st;
      row.want.count  = cnt;
      body_q.push_back(row);
   endfunction

   // Build one body: mostly well-formed chunks with random content, some cut
   // short by the last mark, some with damaged or overlong size lines.
   function automatic void add_random_body();
      logic [7:0] body[$];
      int chunks, size, lead, ext, pick, nd, pos, cut;
      logic [7:0] nib;
      chunks = $urandom_range(0, 4);
      for (int c = 0; c <= chunks; c++) begin
         // The final pass writes the terminating zero-size chunk.
         if (c == chunks) begin
            size = 0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) size = $urandom_range(1, 12);
            else if (pick < 98) size = $urandom_range(13, 64);
            else size = $urandom_range(65, 300);
         end
         lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
         nd = 1;
         while ((size >> (4 * nd)) != 0) nd++;
         repeat (lead) body.push_back("0");
         for (int k = nd - 1; k >= 0; k--) begin
            nib = 8'((size >> (4 * k)) & 15);
            if (nib < 10) body.push_back("0" + nib);
            else body.push_back(($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10);
         end
         // Optional extension, kept short enough to stay under the line limit.
         if ($urandom_range(0, 3) == 0 && 6 - lead - nd >= 1) begin
            ext = $urandom_range(1, 6 - lead - nd);
            body.push_back(";");
            repeat (ext - 1) body.push_back(8'($urandom_range(8'h21, 8'h7E)));
         end
         body.push_back(CH_CR);
         body.push_back(CH_LF);
         if (size != 0) begin
            repeat (size) body.push_back(8'($urandom_range(0, 255)));
            body.push_back(CH_CR);
            body.push_back(CH_LF);
         end
      end
      // A few bytes after the terminator are ignored until the last mark.
      repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));

      pick = $urandom_range(0, 99);
      if (pick >= 80 && pick < 90) begin
         cut = $urandom_range(0, body.size() - 1);
         while (body.size() > cut + 1) void'(body.pop_back());
      end else if (pick >= 90) begin
         repeat ($urandom_range(1, 3)) begin
            pos = $urandom_range(0, body.size() - 1);
            case ($urandom_range(0, 4))
               0:       body[pos] = CH_CR;
               1:       body[pos] = CH_LF;
               2:       body[pos] = "0";
               3:       body[pos] = "F";
               default: body[pos] = 8'($urandom_range(0, 255));
            endcase
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(6, 10)) body.push_front("0" + 8'($urandom_range(0, 9)));
         end
      end
      for (int i = 0; i < body.size(); i++) add_byte(body[i], i == body.size() - 1);
   endfunction

   // ------------------------------------------------------------------
   // Reset, stimulus and the end of the run
   // ------------------------------------------------------------------

   initial begin : sender
      int target;
      body_byte_type row;
      decoded_type   want;
      decoded_type   predicted;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      results_seen   = 0;
      rsp_hold       = 1'b0;
      hold_done      = 1'b0;
      restart_decoder();

      // Empty first chunk, then a byte that is ignored until the last mark.
      add_fixed("0",    1'b0, 1'b0, 8'h00, ST_RUNNING, 0);
      add_fixed(CH_CR,  1'b0, 1'b0, 8'h00, ST_RUNNING, 0);
      add_fixed(CH_LF,  1'b0, 1'b0, 8'h00, ST_EMPTY,   0);
      add_fixed(8'hFF,  1'b1, 1'b0, 8'h00, ST_EMPTY,   0);
      // Two-byte chunk whose size line holds a bare CR and an extension.
      add_byte("2",   1'b0);
      add_byte(CH_CR, 1'b0);
      add_byte(";",   1'b0);
      add_byte(CH_CR, 1'b0);
      add_byte(CH_LF, 1'b0);
      add_fixed(8'h00, 1'b0, 1'b1, 8'h00, ST_RUNNING, 1);
      add_fixed(8'hFF, 1'b0, 1'b1, 8'hFF, ST_RUNNING, 2);
      // CR LF missing after the data, then a lone LF inside the size line.
      add_byte("1",   1'b0);
      add_byte(CH_LF, 1'b0);
      add_byte(CH_CR, 1'b0);
      add_byte(CH_LF, 1'b0);
      // CR as a data byte, then the LF after the data is missing.
      add_byte(CH_CR, 1'b0);
      add_byte(CH_CR, 1'b0);
      add_byte("A",   1'b0);
      add_byte(CH_CR, 1'b0);
      add_byte(CH_LF, 1'b0);
      // A ten-byte chunk cut short by the last mark.
      add_fixed("A", 1'b1, 1'b1, "A", ST_ENDED, 4);
      // Overlong size line, walking both hex letter cases.
      add_byte("a", 1'b0);
      add_byte("B", 1'b0);
      add_byte("c", 1'b0);
      add_byte("D", 1'b0);
      add_byte("e", 1'b0);
      add_byte("F", 1'b0);
      add_byte("9", 1'b0);
      add_fixed("g", 1'b1, 1'b0, 8'h00, ST_TOO_LONG, 0);

      target = body_q.size() + RANDOM_ITEMS;
      while (body_q.size() < target) add_random_body();
      total_items = body_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Offer every byte in order; predict each one as it transfers.
      for (int idx = 0; idx < total_items; idx++) begin
         row = body_q[idx];
         // Halfway through, let the block drain completely.
         if (idx == total_items / 2 && decoded_q.size() != 0) begin
            req_tvalid <= 1'b0;
            while (decoded_q.size() != 0) @(posedge clock);
         end
         if (!rsp_hold && idx < total_items - CALM_TAIL && (idx / 120) % 3 != 2 &&
             $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= row.data;
         req_tlast  <= row.last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         predicted = decode_byte(row.data, row.last);
         want = row.fixed ? row.want : predicted;
         decoded_q.push_back(want);
      end
      req_tvalid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4 * PIPE_LATENCY + QUEUE_DEPTH) @(posedge clock);
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: random stalls, one long hold-off, and checking
   // ------------------------------------------------------------------

   initial begin : receiver
      decoded_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            // Long hold-off while the sender keeps offering, to back up the queue.
            rsp_hold   = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold  = 1'b0;
            hold_done = 1'b1;
         end else if (results_seen < total_items - CALM_TAIL &&
                      (results_seen / 100) % 4 != 3 && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected result %0d: valid %b byte %h status %0d count %0d",
                           results_seen, rsp_tuser, rsp_tdata[7:0], rsp_tdata[9:8],
                           rsp_tdata[26:10]);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tuser !== want.valid || rsp_tdata[7:0] !== want.pbyte ||
                   rsp_tdata[9:8] !== want.status || rsp_tdata[26:10] !== want.count) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"mismatch at result %0d: expected valid %b byte %h ",
                               "status %0d count %0d, got valid %b byte %h status %0d ",
                               "count %0d"},
                              results_seen, want.valid, want.pbyte, want.status,
                              want.count, rsp_tuser, rsp_tdata[7:0], rsp_tdata[9:8],
                              rsp_tdata[26:10]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

### files.f
hdl/hcbd_pkg.sv
hdl/hcbd_front.sv
hdl/hcbd_queue.sv
hdl/hcbd_back.sv
hdl/http_chunked_body_decoder_top.sv
test/http_chunked_body_decoder_top_tb.sv
